[rtl/core/hsv_to_rgb_converter_core_defines.svh]
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Concurrent assertion wrappers; they expand to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define HSV_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define HSV_ASSERT_VLD(label, clk, rst, vld, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (vld) |-> (cond)) else $error(msg);
`else
`define HSV_ASSERT(label, clk, rst, prop, msg)
`define HSV_ASSERT_VLD(label, clk, rst, vld, cond, msg)
`endif
`endif

[rtl/core/hsv2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared widths, fixed-point constants and pipeline payload types.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int CHAN_FRAC = 12;
  localparam int HUE_FRAC  = 7;
  localparam int HUE_W     = 16;
  localparam int CH_W      = CHAN_FRAC + 1;
  localparam int CH_ONE    = 1 << CHAN_FRAC;
  localparam int SECTOR_W  = 60 << HUE_FRAC;
  localparam int SECTORS   = 6;
  localparam int SECT_W    = 3;
  localparam int REM_W     = $clog2(SECTOR_W);
  // Raw quotient hue / SECTOR_W before the mod-6 wrap.
  localparam int Q_W       = $clog2(((1 << HUE_W) - 1) / SECTOR_W + 1);

  // Hue quotient by reciprocal multiply; the estimate is low by at most one.
  localparam int HUE_SHIFT   = 26;
  localparam int HUE_RECIP   = (1 << HUE_SHIFT) / SECTOR_W;
  localparam int HUE_RECIP_W = $clog2(HUE_RECIP + 1);

  // Fraction f = rem * CH_ONE / SECTOR_W by reciprocal multiply.
  localparam int F_SHIFT   = 24;
  localparam longint unsigned F_RECIP =
    (64'd1 << (F_SHIFT + CHAN_FRAC)) / 64'(SECTOR_W);
  localparam int F_RECIP_W = $clog2(F_RECIP + 1);

  localparam int S_TDATA_W = ((HUE_W + 2 * CH_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((3 * CH_W + 7) / 8) * 8;

  typedef logic [CH_W-1:0]   chan_t;
  typedef logic [SECT_W-1:0] sect_t;

  typedef struct packed {
    sect_t            sector;
    logic [REM_W-1:0] rem;
    chan_t            sat;
    chan_t            val;
  } sect_word_t;

  typedef struct packed {
    sect_t                sector;
    logic [CHAN_FRAC-1:0] frac;
    chan_t                sat;
    chan_t                val;
  } frac_word_t;

  typedef struct packed {
    sect_t sector;
    chan_t v;
    chan_t p;
    chan_t q;
    chan_t t;
  } shade_word_t;

endpackage

[rtl/core/hsv_to_rgb_converter_core.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter core
// Streaming pixel converter from Q12 HSV to Q12 RGB.
// ----------------------------------------------------------------------------
// Usage:
//   A pixel word enters on the s_ group: hue in units of 1/128 degree,
//   saturation and brightness in Q12 (4096 is 1.0, larger values clamp).
//   Hue wraps every 360 degrees. The RGB word leaves on the m_ group.
//   The pipeline has 8 register stages. Three stages find the sector and
//   remainder, two form the Q12 fraction, two form the shaded levels, and
//   the last routes them into the output register. Throughput is one word
//   per cycle while the receiver does not stall, set by the fully pipelined
//   multipliers; up to eight words are in flight.
//   The whole pipeline advances together. When the receiver holds m_tready
//   low with a word waiting, every stage holds and s_tready drops in the
//   same cycle; nothing is dropped or repeated, and empty stages ahead of
//   the waiting word stay empty until it is taken.
//   Reset clears all valid bits; the block can take a word as soon as
//   reset is released and needs no setup.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_core_defines.svh"

module hsv_to_rgb_converter_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // hue[15:0], saturation[28:16], brightness[41:29], zero pad
  input  logic [hsv2rgb_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // red[12:0], green[25:13], blue[38:26], zero pad
  output logic [hsv2rgb_pkg::M_TDATA_W-1:0] m_tdata
);

  localparam int SAT_LO = hsv2rgb_pkg::HUE_W;
  localparam int VAL_LO = hsv2rgb_pkg::HUE_W + hsv2rgb_pkg::CH_W;
  localparam int PAD_W  = hsv2rgb_pkg::M_TDATA_W - 3 * hsv2rgb_pkg::CH_W;

  logic                     en;
  logic                     sect_vld;
  hsv2rgb_pkg::sect_word_t  sect_word;
  logic                     frac_vld;
  hsv2rgb_pkg::frac_word_t  frac_word;
  logic                     shd_vld;
  hsv2rgb_pkg::shade_word_t shd;

  hsv2rgb_pkg::chan_t red;
  hsv2rgb_pkg::chan_t green;
  hsv2rgb_pkg::chan_t blue;
  hsv2rgb_pkg::chan_t red_next;
  hsv2rgb_pkg::chan_t green_next;
  hsv2rgb_pkg::chan_t blue_next;

  // The pipeline moves whenever the output register is empty or being drained.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  hsv2rgb_sector u_sector (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_vld     (s_tvalid),
    .hue        (s_tdata[hsv2rgb_pkg::HUE_W-1:0]),
    .saturation (s_tdata[SAT_LO +: hsv2rgb_pkg::CH_W]),
    .brightness (s_tdata[VAL_LO +: hsv2rgb_pkg::CH_W]),
    .out_vld    (sect_vld),
    .out_word   (sect_word)
  );

  hsv2rgb_frac u_frac (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (sect_vld),
    .in_word  (sect_word),
    .out_vld  (frac_vld),
    .out_word (frac_word)
  );

  hsv2rgb_shade u_shade (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (frac_vld),
    .in_word  (frac_word),
    .out_vld  (shd_vld),
    .out_word (shd)
  );

  always_comb begin
    case (shd.sector)
      3'd0: begin
        red_next = shd.v; green_next = shd.t; blue_next = shd.p;
      end
      3'd1: begin
        red_next = shd.q; green_next = shd.v; blue_next = shd.p;
      end
      3'd2: begin
        red_next = shd.p; green_next = shd.v; blue_next = shd.t;
      end
      3'd3: begin
        red_next = shd.p; green_next = shd.q; blue_next = shd.v;
      end
      3'd4: begin
        red_next = shd.t; green_next = shd.p; blue_next = shd.v;
      end
      default: begin
        red_next = shd.v; green_next = shd.p; blue_next = shd.q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= shd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, blue, green, red};

  `HSV_ASSERT_VLD(a_chan_range, clk, rst, m_tvalid, (red <= hsv2rgb_pkg::CH_W'(hsv2rgb_pkg::CH_ONE)) && (green <= hsv2rgb_pkg::CH_W'(hsv2rgb_pkg::CH_ONE)) && (blue <= hsv2rgb_pkg::CH_W'(hsv2rgb_pkg::CH_ONE)), "output channel above one")
  `HSV_ASSERT(a_route_val, clk, rst, (en && shd_vld) |=> ((red == $past(shd.v)) || (green == $past(shd.v)) || (blue == $past(shd.v))), "no output channel carries the value level")

endmodule

[rtl/core/hsv2rgb_sector.sv]
// ----------------------------------------------------------------------------
// HSV to RGB sector stages
// Three stages: clamp and reciprocal multiply, remainder, quotient fix-up.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_core_defines.svh"

module hsv2rgb_sector (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]   hue,
  input  hsv2rgb_pkg::chan_t              saturation,
  input  hsv2rgb_pkg::chan_t              brightness,
  output logic                            out_vld,
  output hsv2rgb_pkg::sect_word_t         out_word
);

  localparam int PROD_W = hsv2rgb_pkg::HUE_W + hsv2rgb_pkg::HUE_RECIP_W;
  localparam int DIFF_W = hsv2rgb_pkg::HUE_W + 1;
  localparam int REM0_W = hsv2rgb_pkg::REM_W + 1;

  // Stage 1
  logic                          s1_vld;
  logic [hsv2rgb_pkg::HUE_W-1:0] s1_hue;
  logic [hsv2rgb_pkg::Q_W-1:0]   s1_qest;
  hsv2rgb_pkg::chan_t            s1_sat;
  hsv2rgb_pkg::chan_t            s1_val;
  // Stage 2
  logic                          s2_vld;
  logic [hsv2rgb_pkg::Q_W-1:0]   s2_qest;
  logic [REM0_W-1:0]             s2_rem0;
  hsv2rgb_pkg::chan_t            s2_sat;
  hsv2rgb_pkg::chan_t            s2_val;

  logic [PROD_W-1:0]           hue_prod;
  hsv2rgb_pkg::chan_t          sat_clamp;
  hsv2rgb_pkg::chan_t          val_clamp;
  logic [DIFF_W-1:0]           diff;
  logic [hsv2rgb_pkg::Q_W-1:0] quot;
  logic [REM0_W-1:0]           rem_fix;
  hsv2rgb_pkg::sect_t          sector_next;

  always_comb begin
    hue_prod  = PROD_W'(hue) * PROD_W'(hsv2rgb_pkg::HUE_RECIP);
    sat_clamp = (saturation > hsv2rgb_pkg::CH_W'(hsv2rgb_pkg::CH_ONE)) ?
                hsv2rgb_pkg::CH_W'(hsv2rgb_pkg::CH_ONE) : saturation;
    val_clamp = (brightness > hsv2rgb_pkg::CH_W'(hsv2rgb_pkg::CH_ONE)) ?
                hsv2rgb_pkg::CH_W'(hsv2rgb_pkg::CH_ONE) : brightness;
  end

  always_comb begin
    diff = DIFF_W'(s1_hue) - DIFF_W'(s1_qest) * DIFF_W'(hsv2rgb_pkg::SECTOR_W);
  end

  // The reciprocal estimate may be one short; fix it, then wrap by six.
  always_comb begin
    if (s2_rem0 >= REM0_W'(hsv2rgb_pkg::SECTOR_W)) begin
      quot    = s2_qest + hsv2rgb_pkg::Q_W'(1);
      rem_fix = s2_rem0 - REM0_W'(hsv2rgb_pkg::SECTOR_W);
    end else begin
      quot    = s2_qest;
      rem_fix = s2_rem0;
    end
    if (quot >= hsv2rgb_pkg::Q_W'(hsv2rgb_pkg::SECTORS)) begin
      sector_next = hsv2rgb_pkg::SECT_W'(quot - hsv2rgb_pkg::Q_W'(hsv2rgb_pkg::SECTORS));
    end else begin
      sector_next = hsv2rgb_pkg::SECT_W'(quot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      s1_vld  <= in_vld;
      s2_vld  <= s1_vld;
      out_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_hue          <= hue;
      s1_qest         <= hue_prod[hsv2rgb_pkg::HUE_SHIFT +: hsv2rgb_pkg::Q_W];
      s1_sat          <= sat_clamp;
      s1_val          <= val_clamp;
      s2_qest         <= s1_qest;
      s2_rem0         <= diff[REM0_W-1:0];
      s2_sat          <= s1_sat;
      s2_val          <= s1_val;
      out_word.sector <= sector_next;
      out_word.rem    <= rem_fix[hsv2rgb_pkg::REM_W-1:0];
      out_word.sat    <= s2_sat;
      out_word.val    <= s2_val;
    end
  end

  `HSV_ASSERT_VLD(a_sector_range, clk, rst, out_vld, out_word.sector < hsv2rgb_pkg::SECT_W'(hsv2rgb_pkg::SECTORS), "sector index out of range")
  `HSV_ASSERT_VLD(a_rem_range, clk, rst, out_vld, out_word.rem < hsv2rgb_pkg::REM_W'(hsv2rgb_pkg::SECTOR_W), "hue remainder not below sector width")

endmodule

[rtl/core/hsv2rgb_frac.sv]
// ----------------------------------------------------------------------------
// HSV to RGB fraction stages
// Two stages: reciprocal multiply of the remainder, then a one-step fix-up.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_core_defines.svh"

module hsv2rgb_frac (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_vld,
  input  hsv2rgb_pkg::sect_word_t in_word,
  output logic                    out_vld,
  output hsv2rgb_pkg::frac_word_t out_word
);

  localparam int PROD_W = hsv2rgb_pkg::REM_W + hsv2rgb_pkg::F_RECIP_W;
  localparam int NUM_W  = hsv2rgb_pkg::REM_W + hsv2rgb_pkg::CHAN_FRAC;

  logic                             s1_vld;
  hsv2rgb_pkg::sect_t               s1_sector;
  logic [hsv2rgb_pkg::REM_W-1:0]    s1_rem;
  logic [hsv2rgb_pkg::CHAN_FRAC-1:0] s1_fest;
  hsv2rgb_pkg::chan_t               s1_sat;
  hsv2rgb_pkg::chan_t               s1_val;

  logic [PROD_W-1:0]                 f_prod;
  logic [NUM_W-1:0]                  resid;
  logic [hsv2rgb_pkg::CHAN_FRAC-1:0] frac_next;

  always_comb begin
    f_prod = PROD_W'(in_word.rem) * PROD_W'(hsv2rgb_pkg::F_RECIP);
  end

  // Residual of rem * ONE against f_est * W shows whether f_est is one short.
  always_comb begin
    resid = {s1_rem, {hsv2rgb_pkg::CHAN_FRAC{1'b0}}}
          - NUM_W'(s1_fest) * NUM_W'(hsv2rgb_pkg::SECTOR_W);
    if (resid >= NUM_W'(hsv2rgb_pkg::SECTOR_W)) begin
      frac_next = s1_fest + hsv2rgb_pkg::CHAN_FRAC'(1);
    end else begin
      frac_next = s1_fest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      s1_vld  <= in_vld;
      out_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sector       <= in_word.sector;
      s1_rem          <= in_word.rem;
      s1_fest         <= f_prod[hsv2rgb_pkg::F_SHIFT +: hsv2rgb_pkg::CHAN_FRAC];
      s1_sat          <= in_word.sat;
      s1_val          <= in_word.val;
      out_word.sector <= s1_sector;
      out_word.frac   <= frac_next;
      out_word.sat    <= s1_sat;
      out_word.val    <= s1_val;
    end
  end

  `HSV_ASSERT_VLD(a_resid_range, clk, rst, s1_vld, resid < NUM_W'(2 * hsv2rgb_pkg::SECTOR_W), "fraction estimate off by more than one")

endmodule

[rtl/core/hsv2rgb_shade.sv]
// ----------------------------------------------------------------------------
// HSV to RGB shade stages
// Two multiply stages forming p, q and t from v, s and the fraction.
// ----------------------------------------------------------------------------
module hsv2rgb_shade (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_vld,
  input  hsv2rgb_pkg::frac_word_t  in_word,
  output logic                     out_vld,
  output hsv2rgb_pkg::shade_word_t out_word
);

  localparam int MUL_W = 2 * hsv2rgb_pkg::CH_W;

  logic               s1_vld;
  hsv2rgb_pkg::sect_t s1_sector;
  hsv2rgb_pkg::chan_t s1_val;
  hsv2rgb_pkg::chan_t s1_p;
  hsv2rgb_pkg::chan_t s1_fs;
  hsv2rgb_pkg::chan_t s1_fcs;

  hsv2rgb_pkg::chan_t frac_c;
  logic [MUL_W-1:0]   fs_prod;
  logic [MUL_W-1:0]   fcs_prod;
  logic [MUL_W-1:0]   p_prod;
  logic [MUL_W-1:0]   q_prod;
  logic [MUL_W-1:0]   t_prod;

  always_comb begin
    frac_c   = hsv2rgb_pkg::CH_W'(hsv2rgb_pkg::CH_ONE)
             - hsv2rgb_pkg::CH_W'(in_word.frac);
    fs_prod  = MUL_W'(in_word.frac) * MUL_W'(in_word.sat);
    fcs_prod = MUL_W'(frac_c) * MUL_W'(in_word.sat);
    p_prod   = MUL_W'(in_word.val)
             * MUL_W'(hsv2rgb_pkg::CH_W'(hsv2rgb_pkg::CH_ONE) - in_word.sat);
  end

  always_comb begin
    q_prod = MUL_W'(s1_val)
           * MUL_W'(hsv2rgb_pkg::CH_W'(hsv2rgb_pkg::CH_ONE) - s1_fs);
    t_prod = MUL_W'(s1_val)
           * MUL_W'(hsv2rgb_pkg::CH_W'(hsv2rgb_pkg::CH_ONE) - s1_fcs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      s1_vld  <= in_vld;
      out_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sector       <= in_word.sector;
      s1_val          <= in_word.val;
      s1_p            <= p_prod[hsv2rgb_pkg::CHAN_FRAC +: hsv2rgb_pkg::CH_W];
      s1_fs           <= fs_prod[hsv2rgb_pkg::CHAN_FRAC +: hsv2rgb_pkg::CH_W];
      s1_fcs          <= fcs_prod[hsv2rgb_pkg::CHAN_FRAC +: hsv2rgb_pkg::CH_W];
      out_word.sector <= s1_sector;
      out_word.v      <= s1_val;
      out_word.p      <= s1_p;
      out_word.q      <= q_prod[hsv2rgb_pkg::CHAN_FRAC +: hsv2rgb_pkg::CH_W];
      out_word.t      <= t_prod[hsv2rgb_pkg::CHAN_FRAC +: hsv2rgb_pkg::CH_W];
    end
  end

endmodule

[tb/hsv_to_rgb_converter_core_tb.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter core testbench
// Drives HSV pixel words through the converter with bursty input and a
// stalling receiver, predicts each RGB word in fixed point and checks the
// output stream in order.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PIXELS = 1330;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 24;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    hsv2rgb_pkg::chan_t val;
    hsv2rgb_pkg::chan_t sat;
    logic [15:0]        hue;
  } hsv_pixel_t;

  typedef struct packed {
    hsv2rgb_pkg::chan_t blue;
    hsv2rgb_pkg::chan_t green;
    hsv2rgb_pkg::chan_t red;
  } rgb_pixel_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [hsv2rgb_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [hsv2rgb_pkg::M_TDATA_W-1:0] m_tdata;

  hsv_pixel_t pixels_to_send[$];
  rgb_pixel_t expected_rgb[$];

  int  total_pixels = 0;
  int  pixels_taken = 0;
  int  mismatches = 0;
  int  cycle_count = 0;
  bit  word_taken = 1'b0;
  int  burst_left = 0;
  int  gap_left = 0;

  hsv_to_rgb_converter_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Fixed-point HSV to RGB: sector and fraction from the hue, then the
  // three shaded levels routed by sector.
  function automatic rgb_pixel_t hsv_to_rgb(hsv_pixel_t px);
    int unsigned one, s, v, sector, rem, frac, p, q, t;
    rgb_pixel_t  rgb;
    one    = hsv2rgb_pkg::CH_ONE;
    s      = (px.sat > one) ? one : px.sat;
    v      = (px.val > one) ? one : px.val;
    sector = (px.hue / hsv2rgb_pkg::SECTOR_W) % hsv2rgb_pkg::SECTORS;
    rem    = px.hue % hsv2rgb_pkg::SECTOR_W;
    frac   = (rem << hsv2rgb_pkg::CHAN_FRAC) / hsv2rgb_pkg::SECTOR_W;
    p = (v * (one - s)) >> hsv2rgb_pkg::CHAN_FRAC;
    q = (v * (one - ((frac * s) >> hsv2rgb_pkg::CHAN_FRAC))) >> hsv2rgb_pkg::CHAN_FRAC;
    t = (v * (one - (((one - frac) * s) >> hsv2rgb_pkg::CHAN_FRAC)))
        >> hsv2rgb_pkg::CHAN_FRAC;
    v = v & ((1 << hsv2rgb_pkg::CH_W) - 1);
    case (sector)
      0: begin rgb.red = v[12:0]; rgb.green = t[12:0]; rgb.blue = p[12:0]; end
      1: begin rgb.red = q[12:0]; rgb.green = v[12:0]; rgb.blue = p[12:0]; end
      2: begin rgb.red = p[12:0]; rgb.green = v[12:0]; rgb.blue = t[12:0]; end
      3: begin rgb.red = p[12:0]; rgb.green = q[12:0]; rgb.blue = v[12:0]; end
      4: begin rgb.red = t[12:0]; rgb.green = p[12:0]; rgb.blue = v[12:0]; end
      default: begin rgb.red = v[12:0]; rgb.green = p[12:0]; rgb.blue = q[12:0]; end
    endcase
    return rgb;
  endfunction

  task automatic queue_pixel(int unsigned hue, int unsigned sat, int unsigned val);
    hsv_pixel_t px;
    px.hue = hue[15:0];
    px.sat = sat[hsv2rgb_pkg::CH_W-1:0];
    px.val = val[hsv2rgb_pkg::CH_W-1:0];
    pixels_to_send.push_back(px);
    total_pixels++;
  endtask

  // Channel values: mostly in range, some above one, some at the extremes.
  function automatic int unsigned pick_channel();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, hsv2rgb_pkg::CH_ONE);
    else if (roll < 85)
      return $urandom_range(hsv2rgb_pkg::CH_ONE + 1, (1 << hsv2rgb_pkg::CH_W) - 1);
    else if (roll < 90) return 0;
    else if (roll < 95) return hsv2rgb_pkg::CH_ONE;
    else return (1 << hsv2rgb_pkg::CH_W) - 1;
  endfunction

  function automatic int unsigned pick_hue();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    // Land near a sector boundary now and then.
    if (roll < 2)
      return ($urandom_range(1, 8) * hsv2rgb_pkg::SECTOR_W + $urandom_range(0, 4) - 2)
             & 16'hFFFF;
    else return $urandom_range(0, 65535);
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    // Extremes of every field and the wrap past a full turn.
    queue_pixel(0, 0, 0);
    queue_pixel(0, hsv2rgb_pkg::CH_ONE, hsv2rgb_pkg::CH_ONE);
    queue_pixel(65535, (1 << hsv2rgb_pkg::CH_W) - 1, (1 << hsv2rgb_pkg::CH_W) - 1);
    queue_pixel(65535, hsv2rgb_pkg::CH_ONE + 1, hsv2rgb_pkg::CH_ONE + 1);
    queue_pixel(hsv2rgb_pkg::SECTOR_W - 1, hsv2rgb_pkg::CH_ONE, hsv2rgb_pkg::CH_ONE);
    queue_pixel(hsv2rgb_pkg::SECTOR_W, hsv2rgb_pkg::CH_ONE, hsv2rgb_pkg::CH_ONE);
    queue_pixel(hsv2rgb_pkg::SECTORS * hsv2rgb_pkg::SECTOR_W - 1, hsv2rgb_pkg::CH_ONE, 3000);
    queue_pixel(hsv2rgb_pkg::SECTORS * hsv2rgb_pkg::SECTOR_W, hsv2rgb_pkg::CH_ONE, 3000);
    queue_pixel(hsv2rgb_pkg::SECTORS * hsv2rgb_pkg::SECTOR_W + 3 * hsv2rgb_pkg::SECTOR_W + 100,
                2048, 4000);
    queue_pixel(4096, 0, 4096);
    queue_pixel(4096, 8191, 0);
    // Two pixels inside each sector.
    for (int k = 0; k < hsv2rgb_pkg::SECTORS; k++) begin
      queue_pixel(k * hsv2rgb_pkg::SECTOR_W + 3000, 3000, 3500);
      queue_pixel(k * hsv2rgb_pkg::SECTOR_W + 5555, hsv2rgb_pkg::CH_ONE, hsv2rgb_pkg::CH_ONE);
    end
    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      queue_pixel(pick_hue(), pick_channel(), pick_channel());
    end
  end

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !word_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pixels_to_send.size() > 0) begin
        s_tdata  <= hsv2rgb_pkg::S_TDATA_W'(pixels_to_send.pop_front());
        s_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: cycles through always ready, random stalls, a sparse pattern
  // and long stall runs.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      case ((cycle_count / 300) % 4)
        0: m_tready <= 1'b1;
        1: m_tready <= $urandom_range(0, 1);
        2: m_tready <= (cycle_count % 4 == 0);
        default: m_tready <= ((cycle_count / 16) % 2 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    hsv_pixel_t px;
    rgb_pixel_t got, want;
    cycle_count <= cycle_count + 1;
    word_taken  <= s_tvalid && s_tready && !rst;
    if (!rst && s_tvalid && s_tready) begin
      px = hsv_pixel_t'(s_tdata[$bits(hsv_pixel_t)-1:0]);
      expected_rgb.push_back(hsv_to_rgb(px));
      pixels_taken++;
    end
    if (!rst && m_tvalid && m_tready) begin
      got = rgb_pixel_t'(m_tdata[$bits(rgb_pixel_t)-1:0]);
      if (expected_rgb.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected output word r=%0d g=%0d b=%0d",
                   got.red, got.green, got.blue);
      end else begin
        want = expected_rgb.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want.red, want.green, want.blue, got.red, got.green, got.blue);
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** hsv_to_rgb_converter_core: FAILED **");
      $finish;
    end
  end

  initial begin
    @(negedge rst);
    while (total_pixels == 0 || pixels_taken < total_pixels) @(posedge clk);
    while (expected_rgb.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_rgb.size() == 0) begin
      $display("** hsv_to_rgb_converter_core: PASSED **");
    end else begin
      $display("** hsv_to_rgb_converter_core: FAILED **");
    end
    $finish;
  end

endmodule
